// ----- sv/one_wire_bus_master_assert.svh -----
// Assertion macros shared by the one-wire bus master RTL.
// Each macro checks on the rising edge of i_clk and is quiet while reset is held.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("one_wire_bus_master: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("one_wire_bus_master: next-cycle check failed");

`endif

// ----- sv/owm_pkg.sv -----
// ----------------------------------------------------------------------------
// owm_pkg
// Types, command codes and register map of the one-wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    localparam int TICK_COUNT_BITS_DEF = 16;

    // Command codes carried on i_func.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Register map.
    localparam int CFG_COUNT     = 8;
    localparam int CFG_SEL_BITS  = $clog2(CFG_COUNT);
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_SEL_BITS-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_SEL_BITS-1:0] CFG_PRES_DELAY   = 3'd1;
    localparam logic [CFG_SEL_BITS-1:0] CFG_PRES_TIMEOUT = 3'd2;
    localparam logic [CFG_SEL_BITS-1:0] CFG_RESET_RECOV  = 3'd3;
    localparam logic [CFG_SEL_BITS-1:0] CFG_WRITE_SLOT   = 3'd4;
    localparam logic [CFG_SEL_BITS-1:0] CFG_READ_SLOT    = 3'd5;
    localparam logic [CFG_SEL_BITS-1:0] CFG_START_LOW    = 3'd6;
    localparam logic [CFG_SEL_BITS-1:0] CFG_READ_SAMPLE  = 3'd7;

    typedef logic [CFG_DATA_BITS-1:0] t_cfg_word;

    localparam t_cfg_word CFG_RESET_VALUE [CFG_COUNT] = '{
        16'd3000, 16'd40, 16'd4000, 16'd150, 16'd40, 16'd50, 16'd1, 16'd2
    };

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_RST_LOW     = 4'd1,
        PH_RST_DELAY   = 4'd2,
        PH_RST_WAIT    = 4'd3,
        PH_RST_RECOVER = 4'd4,
        PH_WRITE       = 4'd5,
        PH_READ        = 4'd6
    } t_phase;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/one_wire_bus_master.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by one tick per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Every input transfer (i_valid/o_ready) is one bus tick: an optional
//   command on i_func (reset/presence, write byte, read byte), the byte to
//   write and the sampled bus level. Every tick yields exactly one result
//   transfer (o_valid/i_ready) with the open-drain drive, busy, done,
//   presence and the last byte read. Bytes go LSB first. A command that
//   arrives while an operation runs is ignored.
//   The result of a tick is registered; one tick is taken every cycle while
//   o_ready is high. The tick is evaluated by a single combinational step
//   between the state registers and a two-entry result buffer.
//   When the receiver stalls, the result buffer holds up to two results;
//   o_ready drops only once its second entry is occupied.
//   Configuration writes (i_cfg_valid/o_cfg_ready) are always taken; an
//   index past the last register is dropped; the user makes them while idle.
//   A synchronous reset (i_rst_n low) restores the default register values,
//   returns the sequencer to idle and empties the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master
    import owm_pkg::*;
#(
    parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_func,
    input  wire logic [7:0]               i_write_data,
    input  wire logic                     i_bus_level,

    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_drive_low,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic                          o_presence,
    output logic [7:0]                    o_read_data,

    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int W  = TICK_COUNT_BITS;
    localparam int CW = (W > CFG_DATA_BITS) ? W : CFG_DATA_BITS;
    localparam logic [W-1:0] TMAX = '1;

    t_cfg_word      r_cfg [CFG_COUNT];

    t_phase         r_phase, n_phase;
    logic [W-1:0]   r_tick, n_tick;
    logic [2:0]     r_bit, n_bit;
    logic [7:0]     r_shift, n_shift;
    logic           r_pres, n_pres;
    logic [7:0]     r_last, n_last;

    t_result        n_res;
    t_result        r_out, r_skid;
    logic           r_out_valid, r_skid_valid;

    logic           in_xfer, out_xfer;
    logic [W-1:0]   clip_len [CFG_READ_SLOT+1];

    assign in_xfer     = i_valid && o_ready;
    assign out_xfer    = r_out_valid && i_ready;
    assign o_ready     = !r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET_VALUE[i];
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_BITS'(CFG_COUNT))) begin
            r_cfg[i_cfg_index[CFG_SEL_BITS-1:0]] <= i_cfg_data;
        end
    end

    // Lengths clipped to the counter range.
    always_comb begin
        for (int i = 0; i <= int'(CFG_READ_SLOT); i++) begin
            clip_len[i] = (CW'(r_cfg[i]) > CW'(TMAX)) ? TMAX : W'(CW'(r_cfg[i]));
        end
    end

    // One bus tick.
    always_comb begin
        logic         v_drive;
        logic         v_done;
        logic [W-1:0] v_slot;
        logic [W:0]   v_tick_p1;

        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pres  = r_pres;
        n_last  = r_last;
        v_drive = 1'b0;
        v_done  = 1'b0;
        v_slot  = '0;

        if (r_phase == PH_IDLE) begin
            n_tick = '0;
            n_bit  = '0;
            case (i_func)
                FUNC_RESET: begin
                    n_pres  = 1'b0;
                    n_phase = PH_RST_LOW;
                end
                FUNC_WRITE: begin
                    n_shift = i_write_data;
                    n_phase = PH_WRITE;
                end
                FUNC_READ: begin
                    n_shift = '0;
                    n_phase = PH_READ;
                end
                default: ;
            endcase
        end

        v_tick_p1 = {1'b0, n_tick} + (W+1)'(1);

        case (n_phase)
            PH_IDLE: ;
            PH_RST_LOW: begin
                v_drive = 1'b1;
                n_tick  = (n_tick == TMAX) ? n_tick : v_tick_p1[W-1:0];
                if (n_tick >= clip_len[CFG_RESET_LOW]) begin
                    n_tick  = '0;
                    n_phase = (r_cfg[CFG_PRES_DELAY] == '0) ? PH_RST_WAIT : PH_RST_DELAY;
                end
            end
            PH_RST_DELAY: begin
                n_tick = (n_tick == TMAX) ? n_tick : v_tick_p1[W-1:0];
                if (n_tick >= clip_len[CFG_PRES_DELAY]) begin
                    n_tick  = '0;
                    n_phase = PH_RST_WAIT;
                end
            end
            PH_RST_WAIT: begin
                if (!i_bus_level) begin
                    n_pres  = 1'b1;
                    n_tick  = '0;
                    n_phase = PH_RST_RECOVER;
                end else begin
                    n_tick = (n_tick == TMAX) ? n_tick : v_tick_p1[W-1:0];
                    if (n_tick >= clip_len[CFG_PRES_TIMEOUT]) begin
                        n_pres  = 1'b0;
                        n_tick  = '0;
                        n_phase = PH_RST_RECOVER;
                    end
                end
                // A zero recovery time ends the reset on the deciding tick.
                if ((n_phase == PH_RST_RECOVER) && (r_cfg[CFG_RESET_RECOV] == '0)) begin
                    n_phase = PH_IDLE;
                    n_bit   = '0;
                    v_done  = 1'b1;
                end
            end
            PH_RST_RECOVER: begin
                n_tick = (n_tick == TMAX) ? n_tick : v_tick_p1[W-1:0];
                if (n_tick >= clip_len[CFG_RESET_RECOV]) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    n_bit   = '0;
                    v_done  = 1'b1;
                end
            end
            PH_WRITE: begin
                v_slot  = clip_len[CFG_WRITE_SLOT];
                v_drive = (CW'(n_tick) < CW'(r_cfg[CFG_START_LOW])) ||
                          (!n_shift[0] && (v_tick_p1 < {1'b0, v_slot}));
                n_tick  = (n_tick == TMAX) ? n_tick : v_tick_p1[W-1:0];
                if (n_tick >= v_slot) begin
                    n_tick  = '0;
                    n_shift = {1'b0, n_shift[7:1]};
                    if (n_bit == 3'd7) begin
                        n_phase = PH_IDLE;
                        n_bit   = '0;
                        v_done  = 1'b1;
                    end else begin
                        n_bit = n_bit + 3'd1;
                    end
                end
            end
            PH_READ: begin
                v_slot  = clip_len[CFG_READ_SLOT];
                v_drive = CW'(n_tick) < CW'(r_cfg[CFG_START_LOW]);
                // A sample point at or past the slot end samples on its last tick.
                if ((CW'(n_tick) == CW'(r_cfg[CFG_READ_SAMPLE])) ||
                    ((v_tick_p1 >= {1'b0, v_slot}) &&
                     (CW'(r_cfg[CFG_READ_SAMPLE]) >= CW'(v_slot)))) begin
                    n_shift = {i_bus_level, n_shift[7:1]};
                end
                n_tick = (n_tick == TMAX) ? n_tick : v_tick_p1[W-1:0];
                if (n_tick >= v_slot) begin
                    n_tick = '0;
                    if (n_bit == 3'd7) begin
                        n_last  = n_shift;
                        n_phase = PH_IDLE;
                        n_bit   = '0;
                        v_done  = 1'b1;
                    end else begin
                        n_bit = n_bit + 3'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_res.drive_low = v_drive;
        n_res.busy_res  = (n_phase != PH_IDLE);
        n_res.done_res  = v_done;
        n_res.presence  = n_pres;
        n_res.read_data = n_last;
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_last  <= '0;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_last  <= n_last;
        end
    end

    // Result buffer: output register plus one skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= in_xfer;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (in_xfer) begin
                    r_skid <= n_res;
                end
            end else if (in_xfer) begin
                r_out <= n_res;
            end
        end else if (in_xfer) begin
            r_skid <= n_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_drive_low = r_out.drive_low;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_presence  = r_out.presence;
    assign o_read_data = r_out.read_data;

`include "one_wire_bus_master_assert.svh"

    `OWM_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid)
    `OWM_ASSERT_SAME(a_idle_counters_clear, r_phase == PH_IDLE, (r_tick == '0) && (r_bit == '0))
    `OWM_ASSERT_SAME(a_done_not_busy, in_xfer && n_res.done_res, !n_res.busy_res)
    `OWM_ASSERT_NEXT(a_state_holds_without_tick, !in_xfer, $stable(r_bit) && $stable(r_tick))

endmodule

`default_nettype wire
